[src/stq_pkg.sv]
// ============================================================================
// stq_pkg
// Shared types and constants of the sorted timer queue core.
// ============================================================================
package stq_pkg;

    localparam int unsigned TIME_W   = 64;
    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned PERIOD_W = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd312500;

    // remainder unit: bits retired per cycle
    localparam int unsigned REM_BITS  = 2;
    localparam int unsigned REM_STEPS = TIME_W / REM_BITS;
    localparam int unsigned REM_CW    = $clog2(REM_STEPS);

    localparam logic [1:0] KIND_EXPIRED = 2'd0;
    localparam logic [1:0] KIND_COMPARE = 2'd1;
    localparam logic [1:0] KIND_ADDED   = 2'd2;
    localparam logic [1:0] KIND_FULL    = 2'd3;

    localparam logic ACTION_ADD   = 1'b0;
    localparam logic ACTION_CHECK = 1'b1;

    typedef struct packed {
        logic                action;
        logic [TIME_W-1:0]   now;
        logic [TIME_W-1:0]   duration;
        logic [HANDLE_W-1:0] handle;
    } t_in_word;

    typedef struct packed {
        logic [1:0]          kind;
        logic [HANDLE_W-1:0] expired_handle;
        logic [TIME_W-1:0]   compare_value;
        logic                heartbeat;
        logic                last;
    } t_out_word;

    typedef enum logic [1:0] {
        EMIT_NONE    = 2'd0,
        EMIT_ADD     = 2'd1,
        EMIT_EXPIRED = 2'd2,
        EMIT_FINAL   = 2'd3
    } t_emit;

    typedef struct packed {
        logic  load;
        logic  insert;
        logic  pop;
        logic  div_start;
        logic  nb_update;
        t_emit emit;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic head_due;
        logic beat_due;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

[src/stq_slot_array.sv]
// ============================================================================
// stq_slot_array
// Sorted timer slots as a row of cells; insert and pop shift the row in place, all cells updated together.
// ============================================================================
module stq_slot_array
    import stq_pkg::*;
#(
    parameter int unsigned TIMER_SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_insert,
    input  logic                i_pop,
    input  logic [TIME_W-1:0]   i_key_exp,
    input  logic [HANDLE_W-1:0] i_key_hdl,
    output logic [TIME_W-1:0]   o_head_exp,
    output logic [HANDLE_W-1:0] o_head_hdl,
    output logic                o_head_valid,
    output logic                o_head_le_key,
    output logic                o_full
);

    localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);

    logic [TIME_W-1:0]   r_slot_exp [TIMER_SLOTS];
    logic [HANDLE_W-1:0] r_slot_hdl [TIMER_SLOTS];
    logic [CW-1:0]       r_cnt;

    logic [TIMER_SLOTS-1:0] w_le;
    logic [TIMER_SLOTS-1:0] w_dn_le;
    logic [TIME_W-1:0]      w_dn_exp [TIMER_SLOTS];
    logic [HANDLE_W-1:0]    w_dn_hdl [TIMER_SLOTS];
    logic [TIME_W-1:0]      w_up_exp [TIMER_SLOTS];
    logic [HANDLE_W-1:0]    w_up_hdl [TIMER_SLOTS];

    for (genvar gi = 0; gi < TIMER_SLOTS; gi++) begin : g_cell
        assign w_le[gi] = (r_cnt > CW'(gi)) && (r_slot_exp[gi] <= i_key_exp);

        if (gi == 0) begin : g_first
            assign w_dn_le[gi]  = 1'b1;
            assign w_dn_exp[gi] = i_key_exp;
            assign w_dn_hdl[gi] = i_key_hdl;
        end else begin : g_lower
            assign w_dn_le[gi]  = w_le[gi-1];
            assign w_dn_exp[gi] = r_slot_exp[gi-1];
            assign w_dn_hdl[gi] = r_slot_hdl[gi-1];
        end

        if (gi == TIMER_SLOTS - 1) begin : g_last
            assign w_up_exp[gi] = r_slot_exp[gi];
            assign w_up_hdl[gi] = r_slot_hdl[gi];
        end else begin : g_upper
            assign w_up_exp[gi] = r_slot_exp[gi+1];
            assign w_up_hdl[gi] = r_slot_hdl[gi+1];
        end

        always_ff @(posedge i_clk) begin
            if (i_insert && !w_le[gi]) begin
                r_slot_exp[gi] <= w_dn_le[gi] ? i_key_exp : w_dn_exp[gi];
                r_slot_hdl[gi] <= w_dn_le[gi] ? i_key_hdl : w_dn_hdl[gi];
            end else if (i_pop) begin
                r_slot_exp[gi] <= w_up_exp[gi];
                r_slot_hdl[gi] <= w_up_hdl[gi];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_insert) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (i_pop) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_head_exp    = r_slot_exp[0];
    assign o_head_hdl    = r_slot_hdl[0];
    assign o_head_valid  = (r_cnt != '0);
    assign o_head_le_key = w_le[0];
    assign o_full        = (r_cnt == CW'(TIMER_SLOTS));

endmodule

[src/stq_rem_div.sv]
// ============================================================================
// stq_rem_div
// Iterative 64 by 32 bit remainder, two dividend bits per cycle.
// ============================================================================
module stq_rem_div
    import stq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [TIME_W-1:0]   i_dividend,
    input  logic [PERIOD_W-1:0] i_divisor,
    output logic                o_done,
    output logic [PERIOD_W-1:0] o_rem
);

    logic                r_busy;
    logic                r_done;
    logic [REM_CW-1:0]   r_cnt;
    logic [TIME_W-1:0]   r_dvd;
    logic [PERIOD_W-1:0] r_dsr;
    logic [PERIOD_W-1:0] r_rem;

    logic [PERIOD_W-1:0] n_rem;
    logic [TIME_W-1:0]   n_dvd;

    always_comb begin
        logic [PERIOD_W:0] rem_w;
        rem_w = {1'b0, r_rem};
        n_dvd = r_dvd;
        for (int k = 0; k < REM_BITS; k++) begin
            rem_w = {rem_w[PERIOD_W-1:0], n_dvd[TIME_W-1]};
            n_dvd = {n_dvd[TIME_W-2:0], 1'b0};
            if (rem_w >= {1'b0, r_dsr}) begin
                rem_w = rem_w - {1'b0, r_dsr};
            end
        end
        n_rem = rem_w[PERIOD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + REM_CW'(1);
            if (r_cnt == REM_CW'(REM_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[src/stq_datapath.sv]
// ============================================================================
// stq_datapath
// Operand registers, period register, slot array, remainder unit, heartbeat deadline and output register.
// ============================================================================
module stq_datapath
    import stq_pkg::*;
#(
    parameter int unsigned TIMER_SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  t_in_word            i_in_word,
    input  logic                i_cfg_we,
    input  logic [PERIOD_W-1:0] i_cfg_wdata,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_word           o_out_word
);

    logic [PERIOD_W-1:0] r_period;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_now_per;
    logic [TIME_W-1:0]   r_exp;
    logic [HANDLE_W-1:0] r_hdl;
    logic [TIME_W-1:0]   r_nb;
    logic                r_beat;
    logic                r_out_valid;
    t_out_word           r_out_word;

    logic [PERIOD_W-1:0] w_per;
    logic [TIME_W-1:0]   w_now_per;
    logic [TIME_W-1:0]   w_head_exp;
    logic [HANDLE_W-1:0] w_head_hdl;
    logic                w_head_valid;
    logic                w_head_le;
    logic                w_full;
    logic                w_div_done;
    logic [PERIOD_W-1:0] w_rem;
    logic                w_out_free;
    t_out_word           n_out_word;

    assign w_per     = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign w_now_per = i_in_word.now + {{(TIME_W-PERIOD_W){1'b0}}, w_per};

    stq_slot_array #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_slots (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_insert      (i_cmd.insert),
        .i_pop         (i_cmd.pop),
        .i_key_exp     (r_exp),
        .i_key_hdl     (r_hdl),
        .o_head_exp    (w_head_exp),
        .o_head_hdl    (w_head_hdl),
        .o_head_valid  (w_head_valid),
        .o_head_le_key (w_head_le),
        .o_full        (w_full)
    );

    stq_rem_div u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_now - r_nb),
        .i_divisor  (w_per),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now     <= i_in_word.now;
            r_now_per <= w_now_per;
            r_exp     <= i_in_word.now + i_in_word.duration;
            r_hdl     <= i_in_word.handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nb   <= '0;
            r_beat <= 1'b0;
        end else if (i_cmd.load) begin
            r_beat <= 1'b0;
            if (i_in_word.action == ACTION_CHECK && r_nb == '0) begin
                r_nb <= w_now_per;
            end
        end else begin
            if (i_cmd.div_start) begin
                r_beat <= 1'b1;
            end
            if (i_cmd.nb_update) begin
                r_nb <= r_now_per - {{(TIME_W-PERIOD_W){1'b0}}, w_rem};
            end
        end
    end

    always_comb begin
        n_out_word = '0;
        case (i_cmd.emit)
            EMIT_ADD: begin
                if (w_full) begin
                    n_out_word.kind = KIND_FULL;
                end else if (w_head_le) begin
                    n_out_word.kind = KIND_ADDED;
                end else begin
                    n_out_word.kind          = KIND_COMPARE;
                    n_out_word.compare_value = r_exp;
                end
                n_out_word.last = 1'b1;
            end
            EMIT_EXPIRED: begin
                n_out_word.kind           = KIND_EXPIRED;
                n_out_word.expired_handle = w_head_hdl;
            end
            EMIT_FINAL: begin
                n_out_word.kind          = KIND_COMPARE;
                n_out_word.compare_value = (w_head_valid && w_head_exp < r_nb) ?
                                           w_head_exp : r_nb;
                n_out_word.heartbeat     = r_beat;
                n_out_word.last          = 1'b1;
            end
            default: begin
                n_out_word = '0;
            end
        endcase
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit != EMIT_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit != EMIT_NONE) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_status.full     = w_full;
    assign o_status.head_due = w_head_valid && (w_head_exp <= r_now);
    assign o_status.beat_due = (r_now >= r_nb);
    assign o_status.div_done = w_div_done;
    assign o_status.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[src/stq_ctrl.sv]
// ============================================================================
// stq_ctrl
// Sequencer for add and check words of the timer queue.
// ============================================================================
module stq_ctrl
    import stq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_action,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ADD  = 5'b00010,
        S_POP  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.emit = EMIT_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_action == ACTION_CHECK) ? S_POP : S_ADD;
                end
            end
            S_ADD: begin
                if (i_status.out_free) begin
                    o_cmd.emit   = EMIT_ADD;
                    o_cmd.insert = !i_status.full;
                    n_state      = S_IDLE;
                end
            end
            S_POP: begin
                if (i_status.head_due) begin
                    if (i_status.out_free) begin
                        o_cmd.emit = EMIT_EXPIRED;
                        o_cmd.pop  = 1'b1;
                    end
                end else if (i_status.beat_due) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.nb_update = 1'b1;
                    n_state         = S_FIN;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.emit = EMIT_FINAL;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[src/sorted_timer_queue_with_heartbeat_core.sv]
// ============================================================================
// sorted_timer_queue_with_heartbeat_core
// Sorted timer table with periodic heartbeat deadline.
// ============================================================================
// One word is handled at a time. An add is accepted, then inserted into
// the sorted cell row, unless full, as its result word is written. A check
// pops expired entries from the head cell, one pop per cycle while the output
// register is free; when the heartbeat deadline has been reached, the
// remainder unit, retiring two bits of the 64-bit time distance per cycle,
// computes the catch-up first. Each word written waits for a free output register.
// ============================================================================
module sorted_timer_queue_with_heartbeat_core
    import stq_pkg::*;
#(
    parameter int unsigned TIMER_SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_word            i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_word           o_out_word,
    input  logic                i_cfg_we,
    input  logic [PERIOD_W-1:0] i_cfg_wdata
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    stq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_word.action),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    stq_datapath #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

[src/stq_checker.sv]
// ============================================================================
// stq_checker
// Port-level checks of the timer queue core, bound to the top level.
// ============================================================================
module stq_checker
    import stq_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input t_out_word           o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_word.kind == KIND_EXPIRED) == !o_out_word.last))
        else $error("last flag does not match kind");

    a_beat_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.heartbeat |->
            o_out_word.kind == KIND_COMPARE && o_out_word.last)
        else $error("heartbeat on a non-final word");

    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.kind != KIND_EXPIRED |->
            o_out_word.expired_handle == '0)
        else $error("handle set on a non-expiry word");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken while busy");

endmodule

bind sorted_timer_queue_with_heartbeat_core stq_checker u_stq_checker (.*);
